// ----- design/collatz_keystream_char_cipher_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Collatz keystream cipher - assertion macros
// Concurrent checks clocked on clk; the first form is masked while in reset.
// ----------------------------------------------------------------------------
`ifndef COLLATZ_KEYSTREAM_CHAR_CIPHER_UNIT_MACROS_SVH
`define COLLATZ_KEYSTREAM_CHAR_CIPHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CKC_ASSERT_RAW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CKC_ASSERT(lbl, prop, msg)

`define CKC_ASSERT_RAW(lbl, prop, msg)

`endif

`endif

// ----- design/ckc_pkg.sv -----
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared widths, constants and types for the Collatz keystream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ckc_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned CHAR_W = 16;

  // printable window of the coded alphabet
  localparam int unsigned FIRST_CODE = 32;
  localparam int unsigned LAST_CODE  = 126;

  // reduced residues (< LAST) and partly reduced ones (< 2*LAST)
  localparam int unsigned MOD_W = $clog2(LAST_CODE);
  localparam int unsigned RED_W = $clog2(2 * LAST_CODE);
  localparam int unsigned DV_W  = CHAR_W + 2;

  // floor(2^N / LAST): quotient estimate is low by at most one
  localparam logic [KEY_W-1:0]  KEY_RECIP  = KEY_W'((64'd1 << KEY_W) / LAST_CODE);
  localparam logic [CHAR_W-1:0] CHAR_RECIP = CHAR_W'((64'd1 << CHAR_W) / LAST_CODE);
  localparam int unsigned       FIRST_MOD  = FIRST_CODE % LAST_CODE;

  localparam logic [CHAR_W-1:0] PRINT_LO = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] PRINT_HI = CHAR_W'(126);

  localparam logic [KEY_W-1:0] SEED_RESET = KEY_W'(1);
  localparam logic [KEY_W-1:0] MIN_RESET  = KEY_W'(1);

  // configuration register indexes
  localparam int unsigned      CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              dir;
  } ckc_tag_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } ckc_pipe_en_t;

endpackage

`default_nettype wire

// ----- design/collatz_keystream_char_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// collatz_keystream_char_cipher_unit
// Character stream cipher keyed by a Collatz sequence on a 32-bit register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_stall   | char_code, restart
//   out_    | output    | out_valid/out_stall | out_char, rejected, nonprint_total
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle while out_stall stays low; an accepted word passes the input
// register, multiply, reduce and result register before it is on out_valid.
// The key register steps at acceptance, so its loop is one add and compare.
// Reset (rst_n low, synchronous) empties the pipe and loads default registers.
// Stalled output lets earlier stages fill; in_stall rises only when all are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "collatz_keystream_char_cipher_unit_macros.svh"

module collatz_keystream_char_cipher_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ckc_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic                          in_restart,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ckc_pkg::CHAR_W-1:0]    out_char,
  output logic                               out_rejected,
  output logic      [ckc_pkg::CHAR_W-1:0]    out_nonprint_total,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ckc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ckc_pkg::KEY_W-1:0]     cfg_data
);
  import ckc_pkg::*;

  logic [KEY_W-1:0] seed_key_r;
  logic [KEY_W-1:0] min_seq_r;
  logic             direction_r;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic load_o, rdy1, rdy2, rdy3;
  logic in_fire, cfg_fire;

  ckc_pipe_en_t     pipe_en;
  ckc_tag_t         tag_in;
  ckc_tag_t         tag_s3;
  logic [KEY_W-1:0] key_nxt;
  logic [MOD_W-1:0] key_mod;
  logic [MOD_W-1:0] ch_mod;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_key_r  <= SEED_RESET;
      min_seq_r   <= MIN_RESET;
      direction_r <= DIR_ENCRYPT;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_SEED_KEY:  seed_key_r  <= cfg_data;
        CFG_MIN_SEQ:   min_seq_r   <= cfg_data;
        CFG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipe flow: each stage moves on when the next one is free or moving
  assign load_o = !out_valid_r || !out_stall;
  assign rdy3   = !v3_r || load_o;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign in_fire  = in_valid && rdy1;

  assign pipe_en.s1 = in_fire;
  assign pipe_en.s2 = v1_r && rdy2;
  assign pipe_en.s3 = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_fire    || (v1_r && !rdy2);
      v2_r        <= pipe_en.s2 || (v2_r && !rdy3);
      v3_r        <= pipe_en.s3 || (v3_r && !load_o);
      out_valid_r <= (v3_r && load_o) || (out_valid_r && out_stall);
    end
  end

  assign tag_in.ch  = in_char_code;
  assign tag_in.dir = direction_r;

  ckc_key_gen u_key_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_fire),
    .restart  (in_restart),
    .seed_key (seed_key_r),
    .min_seq  (min_seq_r),
    .key_nxt  (key_nxt)
  );

  ckc_mod_pipe u_mod_pipe (
    .clk     (clk),
    .en      (pipe_en),
    .key_in  (key_nxt),
    .tag_in  (tag_in),
    .key_mod (key_mod),
    .ch_mod  (ch_mod),
    .tag_out (tag_s3)
  );

  ckc_result u_result (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (v3_r && load_o),
    .key_mod        (key_mod),
    .ch_mod         (ch_mod),
    .tag            (tag_s3),
    .out_char       (out_char),
    .rejected       (out_rejected),
    .nonprint_total (out_nonprint_total)
  );

  assign out_valid = out_valid_r;

  `CKC_ASSERT(a_fire_lands, (in_valid && !in_stall) |=> v1_r, "accepted word lost at entry")
  `CKC_ASSERT(a_full_stall, (out_valid_r && out_stall && v1_r && v2_r && v3_r) |-> in_stall, "word accepted into a full pipe")
  `CKC_ASSERT_RAW(a_reset_empty, !rst_n |=> !out_valid && !v1_r && !v2_r && !v3_r, "pipe not empty after reset")

endmodule

`default_nettype wire

// ----- design/ckc_key_gen.sv -----
// ----------------------------------------------------------------------------
// ckc_key_gen
// Key register with one Collatz step per accepted word and seed reload.
// ----------------------------------------------------------------------------
`default_nettype none
`include "collatz_keystream_char_cipher_unit_macros.svh"

module ckc_key_gen (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic                      restart,
  input  wire logic [ckc_pkg::KEY_W-1:0] seed_key,
  input  wire logic [ckc_pkg::KEY_W-1:0] min_seq,
  output logic      [ckc_pkg::KEY_W-1:0] key_nxt
);
  import ckc_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] base;
  logic [KEY_W-1:0] stepped;

  assign base = restart ? seed_key : key_r;

  always_comb begin
    if (base <= KEY_W'(1)) begin
      stepped = KEY_W'(1);
    end else if (base[0]) begin
      stepped = (base << 1) + base + KEY_W'(1);  // wraps at 32 bits
    end else begin
      stepped = base >> 1;
    end
  end

  assign key_nxt = (stepped <= min_seq) ? seed_key : stepped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= SEED_RESET;
    end else if (advance) begin
      key_r <= key_nxt;
    end
  end

  // a wrapped step to zero always falls back to the seed
  `CKC_ASSERT(a_key_nonzero, advance |=> (key_r != '0) || ($past(seed_key) == '0), "key zero with nonzero seed")

endmodule

`default_nettype wire

// ----- design/ckc_mod_pipe.sv -----
// ----------------------------------------------------------------------------
// ckc_mod_pipe
// Three register stages reducing key and character modulo LAST_CODE.
// ----------------------------------------------------------------------------
`default_nettype none

module ckc_mod_pipe (
  input  wire logic                       clk,
  input  wire ckc_pkg::ckc_pipe_en_t      en,
  input  wire logic [ckc_pkg::KEY_W-1:0]  key_in,
  input  wire ckc_pkg::ckc_tag_t          tag_in,
  output logic      [ckc_pkg::MOD_W-1:0]  key_mod,
  output logic      [ckc_pkg::MOD_W-1:0]  ch_mod,
  output ckc_pkg::ckc_tag_t               tag_out
);
  import ckc_pkg::*;

  localparam logic [KEY_W-1:0] LAST_K = KEY_W'(LAST_CODE);
  localparam logic [RED_W-1:0] LAST_R = RED_W'(LAST_CODE);

  // stage 1: input register
  logic [KEY_W-1:0]   key_s1_r;
  ckc_tag_t           tag_s1_r;
  // stage 2: quotient estimates
  logic [KEY_W-1:0]   key_s2_r;
  logic [KEY_W-1:0]   qk_s2_r;
  logic [CHAR_W-1:0]  qc_s2_r;
  ckc_tag_t           tag_s2_r;
  // stage 3: residues
  logic [MOD_W-1:0]   km_s3_r;
  logic [MOD_W-1:0]   cm_s3_r;
  ckc_tag_t           tag_s3_r;

  logic [2*KEY_W-1:0]  prod_k;
  logic [2*CHAR_W-1:0] prod_c;
  logic [KEY_W-1:0]    rk_full;
  logic [KEY_W-1:0]    rc_full;
  logic [RED_W-1:0]    rk;
  logic [RED_W-1:0]    rc;
  logic [RED_W-1:0]    rk_fix;
  logic [RED_W-1:0]    rc_fix;

  assign prod_k = (2*KEY_W)'(key_s1_r) * (2*KEY_W)'(KEY_RECIP);
  assign prod_c = (2*CHAR_W)'(tag_s1_r.ch) * (2*CHAR_W)'(CHAR_RECIP);

  // remainder is below 2*LAST, so the low bits suffice
  assign rk_full = key_s2_r - (qk_s2_r * LAST_K);
  assign rc_full = KEY_W'(tag_s2_r.ch) - (KEY_W'(qc_s2_r) * LAST_K);
  assign rk      = rk_full[RED_W-1:0];
  assign rc      = rc_full[RED_W-1:0];
  assign rk_fix  = (rk >= LAST_R) ? (rk - LAST_R) : rk;
  assign rc_fix  = (rc >= LAST_R) ? (rc - LAST_R) : rc;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      key_s1_r <= key_in;
      tag_s1_r <= tag_in;
    end
    if (en.s2) begin
      key_s2_r <= key_s1_r;
      qk_s2_r  <= prod_k[2*KEY_W-1:KEY_W];
      qc_s2_r  <= prod_c[2*CHAR_W-1:CHAR_W];
      tag_s2_r <= tag_s1_r;
    end
    if (en.s3) begin
      km_s3_r  <= rk_fix[MOD_W-1:0];
      cm_s3_r  <= rc_fix[MOD_W-1:0];
      tag_s3_r <= tag_s2_r;
    end
  end

  assign key_mod = km_s3_r;
  assign ch_mod  = cm_s3_r;
  assign tag_out = tag_s3_r;

endmodule

`default_nettype wire

// ----- design/ckc_result.sv -----
// ----------------------------------------------------------------------------
// ckc_result
// Final encrypt/decrypt combine, reject flag, nonprintable counter and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "collatz_keystream_char_cipher_unit_macros.svh"

module ckc_result (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire logic [ckc_pkg::MOD_W-1:0]  key_mod,
  input  wire logic [ckc_pkg::MOD_W-1:0]  ch_mod,
  input  wire ckc_pkg::ckc_tag_t          tag,
  output logic      [ckc_pkg::CHAR_W-1:0] out_char,
  output logic                            rejected,
  output logic      [ckc_pkg::CHAR_W-1:0] nonprint_total
);
  import ckc_pkg::*;

  localparam logic [MOD_W:0]  LAST_M  = (MOD_W+1)'(LAST_CODE);
  localparam logic [MOD_W:0]  FIRST_M = (MOD_W+1)'(FIRST_MOD);

  logic [CHAR_W-1:0] char_r;
  logic              rej_r;
  logic [CHAR_W-1:0] cnt_r;

  logic [MOD_W:0]    enc_sum;
  logic [MOD_W:0]    enc_red;
  logic [CHAR_W-1:0] enc_val;
  logic              enc_rej;
  logic              enc_np;
  logic [MOD_W:0]    dm_sum;
  logic [MOD_W:0]    dm_red;
  logic [DV_W-1:0]   dv;
  logic [DV_W-1:0]   dv_adj;
  logic [CHAR_W-1:0] dec_val;
  logic [CHAR_W-1:0] char_nxt;
  logic              rej_nxt;
  logic              cnt_inc;
  logic [CHAR_W-1:0] cnt_nxt;

  // encrypt: (ch + key) mod LAST from the two residues
  assign enc_sum = (MOD_W+1)'(ch_mod) + (MOD_W+1)'(key_mod);
  assign enc_red = (enc_sum >= LAST_M) ? (enc_sum - LAST_M) : enc_sum;
  assign enc_val = CHAR_W'(enc_red);
  assign enc_rej = (tag.ch < CHAR_W'(FIRST_CODE)) || (tag.ch > CHAR_W'(LAST_CODE));
  assign enc_np  = (enc_val < PRINT_LO) || (enc_val > PRINT_HI);

  // decrypt: ch + FIRST - ((key + FIRST) mod LAST), wrapped once, saturated
  assign dm_sum = (MOD_W+1)'(key_mod) + FIRST_M;
  assign dm_red = (dm_sum >= LAST_M) ? (dm_sum - LAST_M) : dm_sum;
  assign dv     = DV_W'(tag.ch) + DV_W'(FIRST_CODE) - DV_W'(dm_red);
  assign dv_adj = dv[DV_W-1] ? (dv + DV_W'(LAST_CODE)) : dv;
  assign dec_val = dv_adj[CHAR_W] ? '1 : dv_adj[CHAR_W-1:0];

  always_comb begin
    if (tag.dir == DIR_DECRYPT) begin
      char_nxt = dec_val;
      rej_nxt  = 1'b0;
      cnt_inc  = 1'b0;
    end else begin
      char_nxt = enc_rej ? '0 : enc_val;
      rej_nxt  = enc_rej;
      cnt_inc  = !enc_rej && enc_np;
    end
  end

  assign cnt_nxt = (cnt_inc && (cnt_r != '1)) ? (cnt_r + CHAR_W'(1)) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      rej_r  <= rej_nxt;
    end
  end

  assign out_char       = char_r;
  assign rejected       = rej_r;
  assign nonprint_total = cnt_r;

  `CKC_ASSERT(a_cnt_monotonic, $past(rst_n) |-> (cnt_r >= $past(cnt_r)), "nonprint count went down")
  `CKC_ASSERT(a_cnt_hold, !load |=> $stable(cnt_r), "nonprint count moved without a word")

endmodule

`default_nettype wire
